[rtl/space_to_depth_address_gen_macros.svh]
// ----------------------------------------------------------------------------
// Space-to-depth address generator assertion macros
// Property shorthands shared by the files that carry assertions.
// ----------------------------------------------------------------------------
`ifndef SPACE_TO_DEPTH_ADDRESS_GEN_MACROS_SVH
`define SPACE_TO_DEPTH_ADDRESS_GEN_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define S2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("space_to_depth_address_gen: next-cycle check failed");

// The consequent must hold the given delay after the antecedent.
`define S2D_ASSERT_DELAY(label, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("space_to_depth_address_gen: delayed check failed");

`endif

[rtl/s2d_pkg.sv]
// ----------------------------------------------------------------------------
// Space-to-depth address generator package
// Field widths, register indexes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package s2d_pkg;

    localparam int STRIDE_BITS = 4;
    localparam int DIM_W       = 13;
    localparam int CNT_W       = 12;
    localparam int REM_W       = 3;
    localparam int IDX_W       = 3;
    localparam int DEST_W      = 24;
    localparam int VALUE_W     = 32;

    localparam logic [IDX_W-1:0] REG_STRIDE_ROWS = 3'd0;
    localparam logic [IDX_W-1:0] REG_STRIDE_COLS = 3'd1;
    localparam logic [IDX_W-1:0] REG_IN_CHANNELS = 3'd2;
    localparam logic [IDX_W-1:0] REG_IN_HEIGHT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_IN_WIDTH    = 3'd4;

    typedef logic [1:0] div_sel_t;

    localparam div_sel_t DIV_OUT_ROWS = 2'd0;
    localparam div_sel_t DIV_OUT_COLS = 2'd1;
    localparam div_sel_t DIV_ROW_POS  = 2'd2;
    localparam div_sel_t DIV_COL_POS  = 2'd3;

    typedef struct packed {
        logic     load_item;
        logic     div_start;
        div_sel_t div_sel;
        logic     mul_plane;
        logic     mul_frame;
        logic     calc_group;
        logic     calc_prod;
        logic     emit;
    } s2d_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } s2d_stat_t;

endpackage

[rtl/s2d_divider.sv]
// ----------------------------------------------------------------------------
// Space-to-depth small divider
// Restoring divider, one quotient bit per cycle, for a stride divisor of 1..8.
// ----------------------------------------------------------------------------
module s2d_divider
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [s2d_pkg::DIM_W-1:0]       dividend,
    input  logic [s2d_pkg::STRIDE_BITS-1:0] divisor,
    output logic                           done,
    output logic [s2d_pkg::DIM_W-1:0]       quotient,
    output logic [s2d_pkg::REM_W-1:0]       remainder
);
    import s2d_pkg::*;

    localparam int CW = $clog2(DIM_W + 1);

    logic [DIM_W-1:0]       quo_reg, quo_next;
    logic [STRIDE_BITS-1:0] rem_reg, rem_next;
    logic [STRIDE_BITS-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [STRIDE_BITS:0]   trial;
    logic [STRIDE_BITS:0]   diff;

    assign trial = {rem_reg, quo_reg[DIM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CW'(DIM_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[STRIDE_BITS-1:0];
                quo_next = {quo_reg[DIM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[STRIDE_BITS-1:0];
                quo_next = {quo_reg[DIM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[REM_W-1:0];

endmodule

[rtl/s2d_ctrl.sv]
// ----------------------------------------------------------------------------
// Space-to-depth controller
// Sequences the setup pass after reset or a register write, then each beat.
// ----------------------------------------------------------------------------
module s2d_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cfg_we,
    input  s2d_pkg::s2d_stat_t   stat,
    output s2d_pkg::s2d_cmd_t    cmd
);
    import s2d_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_PLANE = 3'd2;
    localparam logic [2:0] ST_FRAME = 3'd3;
    localparam logic [2:0] ST_GROUP = 3'd4;
    localparam logic [2:0] ST_PROD  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       pend_reg, pend_next;
    div_sel_t   idx_reg, idx_next;

    assign in_ready = (state_reg == ST_IDLE) && !pend_reg;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg | cfg_we;
        idx_next   = idx_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pend_reg)
                begin
                    pend_next     = cfg_we;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_OUT_ROWS;
                    idx_next      = DIV_OUT_ROWS;
                    state_next    = ST_DIV;
                end
                else if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_GROUP;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    if (idx_reg == DIV_COL_POS)
                    begin
                        state_next = ST_PLANE;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = idx_reg + 1'b1;
                        idx_next      = idx_reg + 1'b1;
                    end
                end
            end
            ST_PLANE:
            begin
                cmd.mul_plane = 1'b1;
                state_next    = ST_FRAME;
            end
            ST_FRAME:
            begin
                cmd.mul_frame = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_GROUP:
            begin
                cmd.calc_group = 1'b1;
                state_next     = ST_PROD;
            end
            ST_PROD:
            begin
                cmd.calc_prod = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b1;
            idx_reg   <= DIV_OUT_ROWS;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

[rtl/s2d_datapath.sv]
// ----------------------------------------------------------------------------
// Space-to-depth datapath
// Register file, raster counters, address arithmetic and the output register.
// ----------------------------------------------------------------------------
module s2d_datapath #(
    parameter int ADDR_BITS = 24,
    parameter int DATA_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [s2d_pkg::IDX_W-1:0]   cfg_index,
    input  logic [s2d_pkg::DIM_W-1:0]   cfg_data,
    input  logic [s2d_pkg::VALUE_W-1:0] elem_value,
    input  s2d_pkg::s2d_cmd_t           cmd,
    output s2d_pkg::s2d_stat_t          stat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [s2d_pkg::DEST_W-1:0]  dest_addr,
    output logic [s2d_pkg::VALUE_W-1:0] out_value
);
    import s2d_pkg::*;

    localparam int PLANE_W = 2 * DIM_W;
    localparam int GRP_W   = 20;
    localparam int PROD_W  = GRP_W + PLANE_W;
    localparam int FRM_W   = PLANE_W + DIM_W;
    localparam int ROWT_W  = CNT_W + DIM_W + 1;
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(4096);
    localparam logic [STRIDE_BITS-1:0] STRIDE_MAX = STRIDE_BITS'(8);

    logic [STRIDE_BITS-1:0] srows_reg, scols_reg;
    logic [DIM_W-1:0]       chans_reg, height_reg, width_reg;

    logic [STRIDE_BITS-1:0] sh, sw;
    logic [DIM_W-1:0]       nc, nh, nw;

    logic [DIM_W-1:0]    oh_reg, ow_reg;
    logic [PLANE_W-1:0]  plane_reg, chw_reg;
    logic [ADDR_BITS-1:0] frame_reg;

    logic [CNT_W-1:0]    chan_reg, row_reg, col_reg;
    logic [CNT_W-1:0]    rq_reg, cq_reg;
    logic [REM_W-1:0]    rr_reg, cr_reg;
    logic [ADDR_BITS-1:0] base_reg;

    logic [DATA_BITS-1:0] val_reg, oval_reg;
    logic [GRP_W-1:0]     grp_reg;
    logic [ADDR_BITS-1:0] prod_reg;
    logic [ROWT_W-1:0]    rowt_reg;
    logic [ADDR_BITS-1:0] dest_reg;
    logic                 ovalid_reg;

    div_sel_t               dsel_reg;
    logic [DIM_W-1:0]       div_dividend;
    logic [STRIDE_BITS-1:0] div_divisor;
    logic                   div_done;
    logic [DIM_W-1:0]       div_quo;
    logic [REM_W-1:0]       div_rem;

    logic [6:0]           blk_idx;
    logic [PROD_W-1:0]    prod_full;
    logic [FRM_W-1:0]     frame_full;
    logic [ADDR_BITS-1:0] addr_sum;
    logic                 col_last, row_last, chan_last;

    function automatic logic [STRIDE_BITS-1:0] clamp_stride(
        input logic [STRIDE_BITS-1:0] v);
        logic [STRIDE_BITS-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = STRIDE_BITS'(1);
        end
        else if (v > STRIDE_MAX)
        begin
            r = STRIDE_MAX;
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        return r;
    endfunction

    assign sh = clamp_stride(srows_reg);
    assign sw = clamp_stride(scols_reg);
    assign nc = clamp_dim(chans_reg);
    assign nh = clamp_dim(height_reg);
    assign nw = clamp_dim(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srows_reg  <= STRIDE_BITS'(2);
            scols_reg  <= STRIDE_BITS'(2);
            chans_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(2);
            width_reg  <= DIM_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STRIDE_ROWS: srows_reg  <= cfg_data[STRIDE_BITS-1:0];
                REG_STRIDE_COLS: scols_reg  <= cfg_data[STRIDE_BITS-1:0];
                REG_IN_CHANNELS: chans_reg  <= cfg_data;
                REG_IN_HEIGHT:   height_reg <= cfg_data;
                REG_IN_WIDTH:    width_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_OUT_ROWS:
            begin
                div_dividend = nh;
                div_divisor  = sh;
            end
            DIV_OUT_COLS:
            begin
                div_dividend = nw;
                div_divisor  = sw;
            end
            DIV_ROW_POS:
            begin
                div_dividend = {1'b0, row_reg};
                div_divisor  = sh;
            end
            default:
            begin
                div_dividend = {1'b0, col_reg};
                div_divisor  = sw;
            end
        endcase
    end

    s2d_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dsel_reg <= cmd.div_sel;
        end
    end

    assign blk_idx    = 7'(rr_reg) + 7'(cr_reg) * 7'(sh);
    assign prod_full  = PROD_W'(grp_reg) * PROD_W'(plane_reg);
    assign frame_full = FRM_W'(chw_reg) * FRM_W'(nw);
    assign addr_sum   = base_reg + prod_reg + ADDR_BITS'(rowt_reg);

    assign col_last  = ({1'b0, col_reg} + 1'b1) >= nw;
    assign row_last  = ({1'b0, row_reg} + 1'b1) >= nh;
    assign chan_last = ({1'b0, chan_reg} + 1'b1) >= nc;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_plane)
        begin
            plane_reg <= PLANE_W'(oh_reg) * PLANE_W'(ow_reg);
            chw_reg   <= PLANE_W'(nc) * PLANE_W'(nh);
        end
        if (cmd.mul_frame)
        begin
            frame_reg <= ADDR_BITS'(frame_full);
        end
        if (div_done && (dsel_reg == DIV_OUT_ROWS))
        begin
            oh_reg <= div_quo;
        end
        if (div_done && (dsel_reg == DIV_OUT_COLS))
        begin
            ow_reg <= div_quo;
        end
        if (cmd.load_item)
        begin
            val_reg <= elem_value[DATA_BITS-1:0];
        end
        if (cmd.calc_group)
        begin
            grp_reg <= GRP_W'(blk_idx) * GRP_W'(nc) + GRP_W'(chan_reg);
        end
        if (cmd.calc_prod)
        begin
            prod_reg <= ADDR_BITS'(prod_full);
            rowt_reg <= ROWT_W'(rq_reg) * ROWT_W'(ow_reg) + ROWT_W'(cq_reg);
        end
        if (cmd.emit)
        begin
            dest_reg <= addr_sum;
            oval_reg <= val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            rq_reg   <= '0;
            rr_reg   <= '0;
            cq_reg   <= '0;
            cr_reg   <= '0;
            base_reg <= '0;
        end
        else if (div_done && (dsel_reg == DIV_ROW_POS))
        begin
            rq_reg <= div_quo[CNT_W-1:0];
            rr_reg <= div_rem;
        end
        else if (div_done && (dsel_reg == DIV_COL_POS))
        begin
            cq_reg <= div_quo[CNT_W-1:0];
            cr_reg <= div_rem;
        end
        else if (cmd.emit)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                cq_reg  <= '0;
                cr_reg  <= '0;
                if (row_last)
                begin
                    row_reg <= '0;
                    rq_reg  <= '0;
                    rr_reg  <= '0;
                    if (chan_last)
                    begin
                        chan_reg <= '0;
                        base_reg <= base_reg + frame_reg;
                    end
                    else
                    begin
                        chan_reg <= chan_reg + 1'b1;
                    end
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                    if (({1'b0, rr_reg} + 1'b1) == sh)
                    begin
                        rr_reg <= '0;
                        rq_reg <= rq_reg + 1'b1;
                    end
                    else
                    begin
                        rr_reg <= rr_reg + 1'b1;
                    end
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
                if (({1'b0, cr_reg} + 1'b1) == sw)
                begin
                    cr_reg <= '0;
                    cq_reg <= cq_reg + 1'b1;
                end
                else
                begin
                    cr_reg <= cr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !ovalid_reg || out_ready;

    assign out_valid = ovalid_reg;
    assign dest_addr = DEST_W'(dest_reg);
    assign out_value = VALUE_W'(oval_reg);

endmodule

[rtl/space_to_depth_address_gen.sv]
// ----------------------------------------------------------------------------
// Space-to-depth address generator
// Tags each tensor element with its index in the space-to-depth output.
// ----------------------------------------------------------------------------
// Elements arrive on the in_valid/in_ready channel in raster order (batch,
// channel, row, column) and leave on the out_valid/out_ready channel with
// their destination index in dest_addr and the element bits in out_value.
// The five shape registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while no beat is in flight (not enforced).
// After reset and after every register write, the block runs a setup pass:
// four 13-step divisions on a shared divider and two multiplies.
// in_ready stays low during this pass.
// Each beat then goes through these steps from acceptance to the output register:
// accept, block-channel product, plane multiply, final sum. One beat is in
// work at a time: the controller takes no new beat before the last one has
// reached the output register, stepping through the two multiplier stages.
// A result waits in the output register while out_ready is low; the next
// beat is accepted and computed meanwhile and holds in its last step until
// the output register frees up.
// Reset clears the raster position and batch offset and loads the default
// shape: strides of two, one channel, two rows and two columns.
// ----------------------------------------------------------------------------
module space_to_depth_address_gen #(
    parameter int ADDR_BITS = 24,
    parameter int DATA_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [s2d_pkg::VALUE_W-1:0] elem_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [s2d_pkg::DEST_W-1:0]  dest_addr,
    output logic [s2d_pkg::VALUE_W-1:0] out_value,
    input  logic                        cfg_we,
    input  logic [s2d_pkg::IDX_W-1:0]   cfg_index,
    input  logic [s2d_pkg::DIM_W-1:0]   cfg_data
);
    import s2d_pkg::*;

    s2d_cmd_t  cmd;
    s2d_stat_t stat;

    s2d_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cfg_we   (cfg_we),
        .stat     (stat),
        .cmd      (cmd)
    );

    s2d_datapath #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .elem_value (elem_value),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dest_addr  (dest_addr),
        .out_value  (out_value)
    );

endmodule

[rtl/s2d_checker.sv]
// ----------------------------------------------------------------------------
// Space-to-depth address generator checker
// Port-level checks on beat sequencing, setup and output holding.
// ----------------------------------------------------------------------------
`include "space_to_depth_address_gen_macros.svh"

module s2d_port_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [s2d_pkg::DEST_W-1:0]  dest_addr,
    input logic [s2d_pkg::VALUE_W-1:0] out_value,
    input logic                        cfg_we
);
    import s2d_pkg::*;

    logic in_beat;
    logic out_stall;

    assign in_beat   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    `S2D_ASSERT_NEXT(a_one_beat_in_work, in_beat, !in_ready)
    `S2D_ASSERT_DELAY(a_result_appears, in_beat, 4, out_valid)
    `S2D_ASSERT_NEXT(a_write_starts_setup, cfg_we, !in_ready)
    `S2D_ASSERT_NEXT(a_out_holds_valid, out_stall, out_valid)
    `S2D_ASSERT_NEXT(a_out_holds_data, out_stall, $stable(dest_addr) && $stable(out_value))

endmodule

bind space_to_depth_address_gen s2d_port_checker u_checker (.*);

[tb/s2d_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Space-to-depth destination index checker
// Watches the shape register port and both element channels. It keeps its
// own raster position, batch offset and shape, works out the destination
// index of every element that enters, and compares each outgoing beat with
// the oldest pending index and element value.
// ----------------------------------------------------------------------------
module s2d_checker #(
    parameter int ADDR_BITS = 24,
    parameter int DATA_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [s2d_pkg::VALUE_W-1:0] elem_value,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [s2d_pkg::DEST_W-1:0]  dest_addr,
    input  logic [s2d_pkg::VALUE_W-1:0] out_value,
    input  logic                        cfg_we,
    input  logic [s2d_pkg::IDX_W-1:0]   cfg_index,
    input  logic [s2d_pkg::DIM_W-1:0]   cfg_data,
    output int                          mismatches,
    output int                          outstanding,
    output int                          frames_seen,
    output int                          beats_checked
);

    import s2d_pkg::*;

    localparam longint unsigned ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;
    localparam longint unsigned DATA_MASK = (64'd1 << DATA_BITS) - 64'd1;

    typedef struct packed {
        logic [DEST_W-1:0]  dest;
        logic [VALUE_W-1:0] value;
    } elem_tag_t;

    elem_tag_t             dest_index_q[$];

    logic [STRIDE_BITS-1:0] stride_rows_r;
    logic [STRIDE_BITS-1:0] stride_cols_r;
    logic [DIM_W-1:0]      chans_r;
    logic [DIM_W-1:0]      height_r;
    logic [DIM_W-1:0]      width_r;

    logic [CNT_W-1:0]      chan_pos;
    logic [CNT_W-1:0]      row_pos;
    logic [CNT_W-1:0]      col_pos;
    logic [ADDR_BITS-1:0]  batch_off;

    function automatic longint unsigned clamp_to(input longint unsigned v,
                                                 input longint unsigned hi);
        if (v < 64'd1)
        begin
            return 64'd1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH %s at %0t ns: got 0x%0h, wanted 0x%0h",
                 what, $time, got, want);
        mismatches++;
    endtask

    task automatic place_element(input logic [VALUE_W-1:0] v);
        longint unsigned sh;
        longint unsigned sw;
        longint unsigned nc;
        longint unsigned nh;
        longint unsigned nw;
        longint unsigned oh;
        longint unsigned ow;
        longint unsigned addr;
        elem_tag_t       tag;
        sh = clamp_to(stride_rows_r, 64'd8);
        sw = clamp_to(stride_cols_r, 64'd8);
        nc = clamp_to(chans_r, 64'd4096);
        nh = clamp_to(height_r, 64'd4096);
        nw = clamp_to(width_r, 64'd4096);
        oh = nh / sh;
        ow = nw / sw;
        addr = batch_off
             + (((row_pos % sh) + (col_pos % sw) * sh) * nc + chan_pos) * oh * ow
             + (row_pos / sh) * ow
             + col_pos / sw;
        addr = addr & ADDR_MASK;
        tag.dest  = addr[DEST_W-1:0];
        tag.value = VALUE_W'(v & DATA_MASK);
        dest_index_q.push_back(tag);

        if (col_pos + 64'd1 >= nw)
        begin
            col_pos = '0;
            if (row_pos + 64'd1 >= nh)
            begin
                row_pos = '0;
                if (chan_pos + 64'd1 >= nc)
                begin
                    chan_pos  = '0;
                    batch_off = ADDR_BITS'((batch_off + nc * nh * nw) & ADDR_MASK);
                    frames_seen++;
                end
                else
                begin
                    chan_pos = chan_pos + 1'b1;
                end
            end
            else
            begin
                row_pos = row_pos + 1'b1;
            end
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        elem_tag_t head;
        if (!rst_n)
        begin
            stride_rows_r = 4'd2;
            stride_cols_r = 4'd2;
            chans_r       = 13'd1;
            height_r      = 13'd2;
            width_r       = 13'd2;
            chan_pos      = '0;
            row_pos       = '0;
            col_pos       = '0;
            batch_off     = '0;
            dest_index_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STRIDE_ROWS: stride_rows_r = cfg_data[STRIDE_BITS-1:0];
                    REG_STRIDE_COLS: stride_cols_r = cfg_data[STRIDE_BITS-1:0];
                    REG_IN_CHANNELS: chans_r       = cfg_data;
                    REG_IN_HEIGHT:   height_r      = cfg_data;
                    REG_IN_WIDTH:    width_r       = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (dest_index_q.size() == 0)
                begin
                    report_mismatch("beat with no element pending", dest_addr, 0);
                end
                else
                begin
                    head = dest_index_q.pop_front();
                    beats_checked++;
                    if (dest_addr !== head.dest)
                    begin
                        report_mismatch("dest_addr", dest_addr, head.dest);
                    end
                    if (out_value !== head.value)
                    begin
                        report_mismatch("out_value", out_value, head.value);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                place_element(elem_value);
            end
            outstanding <= dest_index_q.size();
        end
    end

endmodule

[tb/tb_space_to_depth_address_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Space-to-depth address generator testbench
// Drives element beats and shape settings into the block with random gaps
// and output back-pressure. A directed opening covers the default shape,
// full-size and clamped shapes, uneven sizes and a mid-frame reshape; random
// phases of mostly well-formed small shapes follow. The checker beside the
// block predicts every destination index and reports the mismatch count.
// ----------------------------------------------------------------------------
module tb_space_to_depth_address_gen;

    import s2d_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE_FIRST = REG_IN_WIDTH + 1'b1;
    localparam logic [IDX_W-1:0] REG_SPARE_LAST  = '1;
    localparam int               RANDOM_ELEMS    = 850;
    localparam int               CALM_FIRST      = 300;
    localparam int               CALM_LAST       = 420;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [VALUE_W-1:0]   elem_value;
    logic                 out_valid;
    logic                 out_ready;
    logic [DEST_W-1:0]    dest_addr;
    logic [VALUE_W-1:0]   out_value;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    int                   mismatches;
    int                   outstanding;
    int                   frames_seen;
    int                   beats_checked;
    int                   elems_sent;
    int                   shapes_set;
    bit                   calm;

    space_to_depth_address_gen dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .elem_value (elem_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dest_addr  (dest_addr),
        .out_value  (out_value),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    s2d_checker addr_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .elem_value    (elem_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .dest_addr     (dest_addr),
        .out_value     (out_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .frames_seen   (frames_seen),
        .beats_checked (beats_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 37);
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_shape(input logic [DIM_W-1:0] sh, input logic [DIM_W-1:0] sw,
                             input logic [DIM_W-1:0] c, input logic [DIM_W-1:0] h,
                             input logic [DIM_W-1:0] w);
        write_reg(REG_STRIDE_ROWS, sh);
        write_reg(REG_STRIDE_COLS, sw);
        write_reg(REG_IN_CHANNELS, c);
        write_reg(REG_IN_HEIGHT, h);
        write_reg(REG_IN_WIDTH, w);
        shapes_set++;
    endtask

    task automatic send_elem(input logic [VALUE_W-1:0] v);
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        elem_value <= v;
        do @(posedge clk); while (!in_ready);
        elems_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic pick_shape();
        int                r;
        logic [DIM_W-1:0]  sh;
        logic [DIM_W-1:0]  sw;
        logic [IDX_W-1:0]  idx;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            sh = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(1, 8))
                                             : DIM_W'($urandom_range(1, 4));
            sw = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(1, 8))
                                             : DIM_W'($urandom_range(1, 4));
            set_shape(sh, sw, DIM_W'($urandom_range(1, 3)),
                      DIM_W'(sh * $urandom_range(1, 2)),
                      DIM_W'(sw * $urandom_range(1, 3)));
        end
        else if (r < 80)
        begin
            idx = IDX_W'($urandom_range(REG_STRIDE_ROWS, REG_SPARE_LAST));
            write_reg(idx, ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 8191))
                                                       : DIM_W'($urandom_range(0, 12)));
            shapes_set++;
        end
        else if (r < 95)
        begin
            set_shape(DIM_W'($urandom_range(0, 15)), DIM_W'($urandom_range(0, 15)),
                      DIM_W'($urandom_range(0, 5)), DIM_W'($urandom_range(0, 20)),
                      DIM_W'($urandom_range(0, 20)));
        end
        else
        begin
            set_shape(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)),
                      DIM_W'($urandom_range(0, 8191)), DIM_W'($urandom_range(0, 8191)),
                      DIM_W'($urandom_range(0, 8191)));
        end
    endtask

    initial
    begin : stimulus
        int n;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        elem_value = '0;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_STRIDE_ROWS;
        cfg_data   = '0;
        calm       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_elem(32'h0000_0000);
        send_elem(32'hFFFF_FFFF);
        drain();
        send_elem(32'h5555_5555);
        send_elem(32'hAAAA_AAAA);
        send_elem(32'h0000_0001);
        send_elem(32'h8000_0000);
        drain();

        set_shape(13'd8, 13'd8, 13'd4096, 13'd8191, 13'd4096);
        send_elem(32'h1234_5678);
        send_elem($urandom());
        send_elem(32'hFFFF_0000);
        drain();

        set_shape(13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
        send_elem($urandom());
        send_elem($urandom());
        drain();

        set_shape(13'h1FFF, 13'h0013, 13'd5, 13'd7, 13'd10);
        repeat (4) send_elem($urandom());
        drain();

        write_reg(REG_IN_WIDTH, 13'd2);
        for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
        begin
            write_reg(i[IDX_W-1:0], 13'h1FFF);
        end
        repeat (3) send_elem($urandom());
        drain();

        set_shape(13'd2, 13'd1, 13'd3, 13'd4, 13'd3);
        repeat (4) send_elem($urandom());

        n = elems_sent + RANDOM_ELEMS;
        while (elems_sent < n)
        begin
            drain();
            pick_shape();
            repeat ($urandom_range(8, 60))
            begin
                calm <= (elems_sent >= n - RANDOM_ELEMS + CALM_FIRST)
                     && (elems_sent < n - RANDOM_ELEMS + CALM_LAST);
                if (!calm && $urandom_range(0, 99) < 4)
                begin
                    drain();
                end
                send_elem($urandom());
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Summary: %0d elements over %0d shape settings, %0d beats checked, %0d frames.",
                 elems_sent, shapes_set, beats_checked, frames_seen);
        $display("Shapes covered clamped strides and sizes, uneven and full-size frames, %s",
                 "spare register writes and reshapes in mid-frame.");
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[space_to_depth_address_gen.f]
+incdir+rtl
rtl/s2d_pkg.sv
rtl/s2d_divider.sv
rtl/s2d_ctrl.sv
rtl/s2d_datapath.sv
rtl/space_to_depth_address_gen.sv
rtl/s2d_checker.sv
tb/s2d_checker.sv
tb/tb_space_to_depth_address_gen.sv
